// ----- sv/sbt_pkg.sv -----
// Shared types, constants and helper functions of the source byte tokenizer.
// Used by every module of the block; depends on nothing else.
package sbt_pkg;

  localparam int POSITION_BITS = 24;
  localparam int FIELD_BITS    = 24;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [FIELD_BITS-1:0]    field_t;
  typedef logic [7:0]               char_t;

  localparam pos_t   POS_MAX   = {POSITION_BITS{1'b1}};
  localparam field_t FIELD_MAX = {FIELD_BITS{1'b1}};

  localparam char_t CH_NUL       = 8'h00;
  localparam char_t CH_TAB       = 8'h09;
  localparam char_t CH_NEWLINE   = 8'h0A;
  localparam char_t CH_SPACE     = 8'h20;
  localparam char_t CH_HASH      = 8'h23;
  localparam char_t CH_LPAREN    = 8'h28;
  localparam char_t CH_RPAREN    = 8'h29;
  localparam char_t CH_COLON     = 8'h3A;
  localparam char_t CH_SEMICOLON = 8'h3B;
  localparam char_t CH_EQUALS    = 8'h3D;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_COMMENT = 3'd3,
    MODE_HALTED  = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    KIND_ID        = 4'd0,
    KIND_NUMBER    = 4'd1,
    KIND_EQUALS    = 4'd2,
    KIND_LPAREN    = 4'd3,
    KIND_RPAREN    = 4'd4,
    KIND_COLON     = 4'd5,
    KIND_SEMICOLON = 4'd6,
    KIND_EOF       = 4'd7,
    KIND_ERROR     = 4'd8
  } kind_t;

  typedef struct packed {
    kind_t  kind;
    field_t start;
    field_t length;
    field_t line;
    field_t column;
    field_t index;
    char_t  offending;
    logic   last;
  } result_t;

  typedef struct packed {
    logic    v0;
    result_t r0;
    logic    v1;
    result_t r1;
  } scan_out_t;

  function automatic pos_t sat_inc(pos_t v);
    pos_t r;
    r = (v == POS_MAX) ? v : v + pos_t'(1);
    return r;
  endfunction

  function automatic field_t clamp_field(pos_t v);
    logic [POSITION_BITS+FIELD_BITS-1:0] wide;
    field_t r;
    wide = {{FIELD_BITS{1'b0}}, v};
    if ((wide >> FIELD_BITS) != '0) begin
      r = FIELD_MAX;
    end else begin
      r = wide[FIELD_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic is_alpha(char_t c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(char_t c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic kind_t punct_kind(char_t c);
    kind_t k;
    case (c)
      CH_EQUALS:    k = KIND_EQUALS;
      CH_LPAREN:    k = KIND_LPAREN;
      CH_RPAREN:    k = KIND_RPAREN;
      CH_COLON:     k = KIND_COLON;
      CH_SEMICOLON: k = KIND_SEMICOLON;
      default:      k = KIND_ERROR;
    endcase
    return k;
  endfunction

endpackage

// ----- sv/sbt_scanner.sv -----
// Scan state (mode, position, token start) and per-byte classification.
// Produces up to two results per transfer; uses sbt_pkg.
module sbt_scanner (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  sbt_pkg::char_t    source_byte,
  output sbt_pkg::scan_out_t scan_out
);

  sbt_pkg::mode_t  mode, mode_next;
  sbt_pkg::pos_t   line, line_next;
  sbt_pkg::pos_t   column, column_next;
  sbt_pkg::pos_t   index, index_next;
  sbt_pkg::pos_t   token_begin, token_begin_next;

  sbt_pkg::pos_t   cons_line, cons_column, cons_index;
  sbt_pkg::result_t pend_tok, p2_tok;
  logic            pend, skip, p2_valid;
  sbt_pkg::kind_t  pk;
  sbt_pkg::char_t  c;

  assign c = source_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= sbt_pkg::MODE_IDLE;
      line        <= sbt_pkg::pos_t'(1);
      column      <= sbt_pkg::pos_t'(1);
      index       <= '0;
      token_begin <= '0;
    end else if (fire) begin
      mode        <= mode_next;
      line        <= line_next;
      column      <= column_next;
      index       <= index_next;
      token_begin <= token_begin_next;
    end
  end

  always_comb begin
    if (c == sbt_pkg::CH_NEWLINE) begin
      cons_line   = sbt_pkg::sat_inc(line);
      cons_column = sbt_pkg::pos_t'(1);
    end else begin
      cons_line   = line;
      cons_column = sbt_pkg::sat_inc(column);
    end
    cons_index = sbt_pkg::sat_inc(index);

    mode_next        = mode;
    line_next        = line;
    column_next      = column;
    index_next       = index;
    token_begin_next = token_begin;
    pend             = 1'b0;
    skip             = 1'b0;
    p2_valid         = 1'b0;
    pk               = sbt_pkg::punct_kind(c);

    case (mode)
      sbt_pkg::MODE_HALTED:  skip = (c != sbt_pkg::CH_NUL);
      sbt_pkg::MODE_COMMENT: skip = (c != sbt_pkg::CH_NUL);
      sbt_pkg::MODE_IDENT: begin
        if (sbt_pkg::is_alpha(c) || sbt_pkg::is_digit(c)) begin
          skip = 1'b1;
        end else begin
          pend = 1'b1;
        end
      end
      sbt_pkg::MODE_NUMBER: begin
        if (sbt_pkg::is_digit(c)) begin
          skip = 1'b1;
        end else begin
          pend = 1'b1;
        end
      end
      default: ;
    endcase

    pend_tok.kind      = (mode == sbt_pkg::MODE_NUMBER) ? sbt_pkg::KIND_NUMBER
                                                        : sbt_pkg::KIND_ID;
    pend_tok.start     = sbt_pkg::clamp_field(token_begin);
    pend_tok.length    = sbt_pkg::clamp_field(index - token_begin);
    pend_tok.line      = sbt_pkg::clamp_field(line);
    pend_tok.column    = sbt_pkg::clamp_field(column);
    pend_tok.index     = sbt_pkg::clamp_field(index);
    pend_tok.offending = sbt_pkg::CH_NUL;
    pend_tok.last      = 1'b0;

    p2_tok = pend_tok;
    p2_tok.start     = sbt_pkg::clamp_field(index);
    p2_tok.offending = c;

    if (skip) begin
      if (mode != sbt_pkg::MODE_HALTED) begin
        line_next   = cons_line;
        column_next = cons_column;
        index_next  = cons_index;
        if (mode == sbt_pkg::MODE_COMMENT && c == sbt_pkg::CH_NEWLINE) begin
          mode_next = sbt_pkg::MODE_IDLE;
        end
      end
    end else begin
      mode_next = sbt_pkg::MODE_IDLE;
      if (c == sbt_pkg::CH_NUL) begin
        p2_valid         = 1'b1;
        p2_tok.kind      = sbt_pkg::KIND_EOF;
        p2_tok.length    = '0;
        p2_tok.offending = sbt_pkg::CH_NUL;
        line_next        = sbt_pkg::pos_t'(1);
        column_next      = sbt_pkg::pos_t'(1);
        index_next       = '0;
        token_begin_next = '0;
      end else if (c == sbt_pkg::CH_SPACE || c == sbt_pkg::CH_TAB ||
                   c == sbt_pkg::CH_NEWLINE) begin
        line_next   = cons_line;
        column_next = cons_column;
        index_next  = cons_index;
      end else if (sbt_pkg::is_alpha(c) || sbt_pkg::is_digit(c) ||
                   c == sbt_pkg::CH_HASH) begin
        if (c == sbt_pkg::CH_HASH) begin
          mode_next = sbt_pkg::MODE_COMMENT;
        end else begin
          mode_next        = sbt_pkg::is_digit(c) ? sbt_pkg::MODE_NUMBER
                                                   : sbt_pkg::MODE_IDENT;
          token_begin_next = index;
        end
        line_next   = cons_line;
        column_next = cons_column;
        index_next  = cons_index;
      end else if (pk == sbt_pkg::KIND_ERROR) begin
        p2_valid      = 1'b1;
        p2_tok.kind   = sbt_pkg::KIND_ERROR;
        p2_tok.length = sbt_pkg::field_t'(1);
        mode_next     = sbt_pkg::MODE_HALTED;
      end else begin
        p2_valid      = 1'b1;
        p2_tok.kind   = pk;
        p2_tok.length = sbt_pkg::clamp_field(cons_index - index);
        p2_tok.line   = sbt_pkg::clamp_field(cons_line);
        p2_tok.column = sbt_pkg::clamp_field(cons_column);
        p2_tok.index  = sbt_pkg::clamp_field(cons_index);
        line_next     = cons_line;
        column_next   = cons_column;
        index_next    = cons_index;
      end
    end

    if (pend) begin
      scan_out.v0      = fire;
      scan_out.r0      = pend_tok;
      scan_out.r0.last = !p2_valid;
      scan_out.v1      = fire && p2_valid;
      scan_out.r1      = p2_tok;
      scan_out.r1.last = 1'b1;
    end else begin
      scan_out.v0      = fire && p2_valid;
      scan_out.r0      = p2_tok;
      scan_out.r0.last = 1'b1;
      scan_out.v1      = 1'b0;
      scan_out.r1      = p2_tok;
    end
  end

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (fire && mode == sbt_pkg::MODE_HALTED && source_byte != sbt_pkg::CH_NUL)
      |-> (!scan_out.v0 && !scan_out.v1 && mode_next == sbt_pkg::MODE_HALTED))
    else $error("halted scanner produced a result or left halt");

  a_eof_resets: assert property (@(posedge clk) disable iff (rst)
    (fire && source_byte == sbt_pkg::CH_NUL)
      |=> (mode == sbt_pkg::MODE_IDLE && index == '0))
    else $error("end of source did not reset the position");

endmodule

// ----- sv/sbt_result_queue.sv -----
// Small result queue: takes up to two results per cycle, hands out one unless
// the output stalls. Decouples the scanner from output stall; uses sbt_pkg.
module sbt_result_queue (
  input  logic               clk,
  input  logic               rst,
  input  sbt_pkg::scan_out_t push,
  output logic               room,
  output logic               head_valid,
  input  logic               head_stall,
  output sbt_pkg::result_t   head
);

  sbt_pkg::result_t mem [sbt_pkg::QUEUE_DEPTH];

  logic [sbt_pkg::QPTR_BITS-1:0]   rd_ptr, wr_ptr, wr_ptr_next;
  logic [sbt_pkg::QCOUNT_BITS-1:0] count, count_next;
  logic [sbt_pkg::QCOUNT_BITS-1:0] n_push;
  logic                            pop;

  assign n_push     = sbt_pkg::QCOUNT_BITS'(push.v0) + sbt_pkg::QCOUNT_BITS'(push.v1);
  assign head_valid = (count != '0);
  assign pop        = head_valid && !head_stall;
  assign room       = (count <= sbt_pkg::QCOUNT_BITS'(sbt_pkg::QUEUE_DEPTH - 2));
  assign wr_ptr_next = wr_ptr + n_push[sbt_pkg::QPTR_BITS-1:0];
  assign count_next = count + n_push - sbt_pkg::QCOUNT_BITS'(pop);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + sbt_pkg::QPTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.v1) begin
      mem[wr_ptr + sbt_pkg::QPTR_BITS'(1)] <= push.r1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= sbt_pkg::QCOUNT_BITS'(sbt_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push.v0 |-> room)
    else $error("push without room");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    (!push.v0 && !pop) |=> $stable(count))
    else $error("queue count moved without push or pop");

endmodule

// ----- sv/source_byte_tokenizer.sv -----
// Source byte tokenizer: one source byte in per transfer, token results out.
// A byte enters an input register; once the queue has room, the scanner classifies it
// and updates line, column and index, pushing zero, one or two results into a
// four-entry result queue. The block takes one byte per cycle while the queue
// has room for two results; a byte that yields two results (a pending identifier
// or number followed by punctuation, an error or end of file) leaves one more
// result for the output, which the queue absorbs. Uses sbt_pkg, sbt_scanner
// and sbt_result_queue.
module source_byte_tokenizer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            source_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [3:0]            token_kind,
  output sbt_pkg::field_t       token_start,
  output sbt_pkg::field_t       token_length,
  output sbt_pkg::field_t       after_line,
  output sbt_pkg::field_t       after_column,
  output sbt_pkg::field_t       after_index,
  output logic [7:0]            offending_byte,
  output logic                  last_of_run
);

  logic               held_valid;
  sbt_pkg::char_t     held_byte;
  logic               room;
  logic               fire;
  sbt_pkg::scan_out_t scan_out;
  sbt_pkg::result_t   head;

  assign fire     = held_valid && room;
  assign in_stall = held_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_byte <= source_byte;
    end
  end

  sbt_scanner u_scanner (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .source_byte (held_byte),
    .scan_out    (scan_out)
  );

  sbt_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (scan_out),
    .room       (room),
    .head_valid (out_valid),
    .head_stall (out_stall),
    .head       (head)
  );

  assign token_kind     = head.kind;
  assign token_start    = head.start;
  assign token_length   = head.length;
  assign after_line     = head.line;
  assign after_column   = head.column;
  assign after_index    = head.index;
  assign offending_byte = head.offending;
  assign last_of_run    = head.last;

endmodule

// ----- tb/sv/source_byte_tokenizer_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for source_byte_tokenizer: directed, random and back-pressure
// source streams, with a behavioral scanner predicting every token. Depends on sbt_pkg.
module source_byte_tokenizer_test;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  sbt_pkg::char_t source_byte = sbt_pkg::CH_NUL;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] token_kind;
  sbt_pkg::field_t token_start;
  sbt_pkg::field_t token_length;
  sbt_pkg::field_t after_line;
  sbt_pkg::field_t after_column;
  sbt_pkg::field_t after_index;
  logic [7:0] offending_byte;
  logic last_of_run;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int mismatch_count = 0;
  int bytes_sent = 0;

  sbt_pkg::result_t expected_tokens[$];

  sbt_pkg::mode_t lex_mode = sbt_pkg::MODE_IDLE;
  sbt_pkg::pos_t lex_line = sbt_pkg::pos_t'(1);
  sbt_pkg::pos_t lex_column = sbt_pkg::pos_t'(1);
  sbt_pkg::pos_t lex_index = '0;
  sbt_pkg::pos_t lex_begin = '0;

  sbt_pkg::char_t punct_list[5] = '{sbt_pkg::CH_EQUALS, sbt_pkg::CH_LPAREN,
                                    sbt_pkg::CH_RPAREN, sbt_pkg::CH_COLON,
                                    sbt_pkg::CH_SEMICOLON};

  source_byte_tokenizer uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .source_byte(source_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .token_kind(token_kind),
    .token_start(token_start),
    .token_length(token_length),
    .after_line(after_line),
    .after_column(after_column),
    .after_index(after_index),
    .offending_byte(offending_byte),
    .last_of_run(last_of_run)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic is_letter(sbt_pkg::char_t c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_numeral(sbt_pkg::char_t c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic sbt_pkg::pos_t bump(sbt_pkg::pos_t v);
    return (v == '1) ? v : v + sbt_pkg::pos_t'(1);
  endfunction

  function automatic void advance(sbt_pkg::char_t c);
    if (c == sbt_pkg::CH_NEWLINE) begin
      lex_line = bump(lex_line);
      lex_column = sbt_pkg::pos_t'(1);
    end else begin
      lex_column = bump(lex_column);
    end
    lex_index = bump(lex_index);
  endfunction

  function automatic sbt_pkg::result_t token_result(sbt_pkg::kind_t k, sbt_pkg::pos_t first,
                                                    sbt_pkg::pos_t len, sbt_pkg::char_t ch);
    sbt_pkg::result_t r;
    r.kind = k;
    r.start = first;
    r.length = len;
    r.line = lex_line;
    r.column = lex_column;
    r.index = lex_index;
    r.offending = ch;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic predict_tokens(input sbt_pkg::char_t c);
    sbt_pkg::result_t found[$];
    sbt_pkg::pos_t first;
    sbt_pkg::kind_t pk;
    if (lex_mode == sbt_pkg::MODE_HALTED && c != sbt_pkg::CH_NUL) return;
    if (lex_mode == sbt_pkg::MODE_IDENT) begin
      if (is_letter(c) || is_numeral(c)) begin
        advance(c);
        return;
      end
      found.push_back(token_result(sbt_pkg::KIND_ID, lex_begin, lex_index - lex_begin,
                                   sbt_pkg::CH_NUL));
      lex_mode = sbt_pkg::MODE_IDLE;
    end else if (lex_mode == sbt_pkg::MODE_NUMBER) begin
      if (is_numeral(c)) begin
        advance(c);
        return;
      end
      found.push_back(token_result(sbt_pkg::KIND_NUMBER, lex_begin, lex_index - lex_begin,
                                   sbt_pkg::CH_NUL));
      lex_mode = sbt_pkg::MODE_IDLE;
    end else if (lex_mode == sbt_pkg::MODE_COMMENT && c != sbt_pkg::CH_NUL) begin
      if (c == sbt_pkg::CH_NEWLINE) lex_mode = sbt_pkg::MODE_IDLE;
      advance(c);
      return;
    end
    if (c == sbt_pkg::CH_NUL) begin
      found.push_back(token_result(sbt_pkg::KIND_EOF, lex_index, '0, sbt_pkg::CH_NUL));
      lex_mode = sbt_pkg::MODE_IDLE;
      lex_line = sbt_pkg::pos_t'(1);
      lex_column = sbt_pkg::pos_t'(1);
      lex_index = '0;
      lex_begin = '0;
    end else if (c == sbt_pkg::CH_SPACE || c == sbt_pkg::CH_TAB ||
                 c == sbt_pkg::CH_NEWLINE) begin
      advance(c);
    end else if (is_letter(c)) begin
      lex_begin = lex_index;
      lex_mode = sbt_pkg::MODE_IDENT;
      advance(c);
    end else if (is_numeral(c)) begin
      lex_begin = lex_index;
      lex_mode = sbt_pkg::MODE_NUMBER;
      advance(c);
    end else if (c == sbt_pkg::CH_HASH) begin
      lex_mode = sbt_pkg::MODE_COMMENT;
      advance(c);
    end else begin
      case (c)
        sbt_pkg::CH_EQUALS: pk = sbt_pkg::KIND_EQUALS;
        sbt_pkg::CH_LPAREN: pk = sbt_pkg::KIND_LPAREN;
        sbt_pkg::CH_RPAREN: pk = sbt_pkg::KIND_RPAREN;
        sbt_pkg::CH_COLON: pk = sbt_pkg::KIND_COLON;
        sbt_pkg::CH_SEMICOLON: pk = sbt_pkg::KIND_SEMICOLON;
        default: pk = sbt_pkg::KIND_ERROR;
      endcase
      if (pk == sbt_pkg::KIND_ERROR) begin
        found.push_back(token_result(sbt_pkg::KIND_ERROR, lex_index, sbt_pkg::pos_t'(1), c));
        lex_mode = sbt_pkg::MODE_HALTED;
      end else begin
        first = lex_index;
        advance(c);
        found.push_back(token_result(pk, first, lex_index - first, c));
      end
    end
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    foreach (found[i]) expected_tokens.push_back(found[i]);
  endtask

  task automatic send_byte(input sbt_pkg::char_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    source_byte <= b;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    predict_tokens(b);
    bytes_sent++;
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic sbt_pkg::char_t random_letter();
    sbt_pkg::char_t base;
    base = $urandom_range(0, 1) ? "a" : "A";
    return base + sbt_pkg::char_t'($urandom_range(0, 25));
  endfunction

  function automatic sbt_pkg::char_t random_numeral();
    return "0" + sbt_pkg::char_t'($urandom_range(0, 9));
  endfunction

  task automatic send_fragment();
    int pick;
    int n;
    sbt_pkg::char_t c;
    pick = $urandom_range(0, 99);
    n = $urandom_range(1, 8);
    if (pick < 30) begin
      send_byte(random_letter());
      repeat (n - 1) send_byte($urandom_range(0, 3) == 0 ? random_numeral() : random_letter());
    end else if (pick < 45) begin
      repeat (n) send_byte(random_numeral());
    end else if (pick < 65) begin
      send_byte(punct_list[$urandom_range(0, 4)]);
    end else if (pick < 82) begin
      case ($urandom_range(0, 2))
        0: send_byte(sbt_pkg::CH_SPACE);
        1: send_byte(sbt_pkg::CH_TAB);
        default: send_byte(sbt_pkg::CH_NEWLINE);
      endcase
    end else if (pick < 95) begin
      send_byte(sbt_pkg::CH_HASH);
      repeat (n) begin
        do c = sbt_pkg::char_t'($urandom_range(1, 255)); while (c == sbt_pkg::CH_NEWLINE);
        send_byte(c);
      end
      if ($urandom_range(0, 3) != 0) send_byte(sbt_pkg::CH_NEWLINE);
    end else begin
      send_byte(sbt_pkg::char_t'($urandom_range(1, 255)));
    end
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_text("Zz9 =(42);:\n#x");
    send_byte(sbt_pkg::CH_NUL);
    send_text("\ta");
    send_byte(sbt_pkg::CH_NUL);
    send_text("7");
    send_byte(sbt_pkg::CH_NUL);
    send_text("k");
    send_byte(8'hFF);
    send_text("b");
    send_byte(sbt_pkg::CH_NUL);
    idle_input();
  endtask

  task automatic test_random_source(input int idle_pct, input int stall_pct, input int budget);
    int stop_at;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      repeat ($urandom_range(1, 25)) send_fragment();
      send_byte(sbt_pkg::CH_NUL);
    end
    idle_input();
  endtask

  task automatic test_fill_and_stall();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 200;
    repeat (40) send_byte(punct_list[$urandom_range(0, 4)]);
    send_byte(sbt_pkg::CH_NUL);
    idle_input();
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [23:0] want, input logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(negedge clk) begin : check_results
    sbt_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected result, kind %0d start %0d", $time, token_kind, token_start);
        mismatch_count++;
      end else begin
        want = expected_tokens.pop_front();
        check_field("token_kind", 24'(want.kind), 24'(token_kind));
        check_field("token_start", want.start, token_start);
        check_field("token_length", want.length, token_length);
        check_field("after_line", want.line, after_line);
        check_field("after_column", want.column, after_column);
        check_field("after_index", want.index, after_index);
        check_field("offending_byte", 24'(want.offending), 24'(offending_byte));
        check_field("last_of_run", 24'(want.last), 24'(last_of_run));
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_random_source(0, 0, 500);
    test_random_source(45, 0, 500);
    test_random_source(0, 45, 500);
    test_random_source(6, 6, 500);
    test_fill_and_stall();
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("source_byte_tokenizer_test passed");
    end else begin
      $display("source_byte_tokenizer_test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("source_byte_tokenizer_test failed");
    $finish;
  end

endmodule

// ----- source_byte_tokenizer.f -----
sv/sbt_pkg.sv
sv/sbt_scanner.sv
sv/sbt_result_queue.sv
sv/source_byte_tokenizer.sv
tb/sv/source_byte_tokenizer_test.sv
